// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property on clk, switched off while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/tgcw_pkg.sv =====
// types, step codes and 5x8 font table for the text glyph column writer
`timescale 1ns / 1ps

package tgcw_pkg;

    localparam int GLYPH_WIDTH = 5;
    localparam int GLYPH_COUNT = 95;
    localparam int FONT_ROW_W  = GLYPH_WIDTH * 8;

    localparam logic       OP_PRINT      = 1'b0;
    localparam logic       OP_SET_CURSOR = 1'b1;

    localparam logic [7:0] CMD_COL_ADDR  = 8'h21;
    localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_FIRST      = 8'h20;
    localparam logic [7:0] CH_LAST       = 8'h7E;
    localparam logic [7:0] BLANK_COLUMN  = 8'h00;

    localparam int         STEP_W        = 4;

    localparam logic [STEP_W-1:0] STEP_COL_CMD  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_COL_LO   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_COL_HI   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_PAGE_CMD = 4'd3;
    localparam logic [STEP_W-1:0] STEP_PAGE_LO  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_PAGE_HI  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_GLYPH0   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_GLYPH1   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_GLYPH2   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_GLYPH3   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_GLYPH4   = 4'd10;
    localparam logic [STEP_W-1:0] STEP_BLANK    = 4'd11;

    typedef logic [FONT_ROW_W-1:0] font_row_t;
    typedef logic [6:0]            glyph_idx_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] char_code;
        logic [7:0] line;
        logic [7:0] column;
    } tgcw_cmd_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_command;
        logic       last;
    } tgcw_byte_t;

    // leftmost column in the top byte
    localparam font_row_t FONT_ROM [GLYPH_COUNT] = '{
        40'h0000000000, 40'h00002F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0000A06000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324959513E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h55AA55AA55, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
        40'h0003050000, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h18A4A4A47C,
        40'h7F08040478, 40'h00447D4000, 40'h4080847D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'hFC24242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h1CA0A0A07C, 40'h4464544C44, 40'h00107C8200,
        40'h0000FF0000, 40'h00827C1000, 40'h0006090906
    };

endpackage

// ===== hw/rtl/tgcw_stream_if.sv =====
// valid/ready channel carrying one payload item per handshake
`timescale 1ns / 1ps

interface tgcw_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/text_glyph_column_writer.sv =====
// text glyph column writer: characters in, display controller bytes out
//
// req carries one item per handshake: operation, char_code, line, column.
// operation print sends five font columns and one blank column (six bytes), after
// a six-byte window command on wrap; a newline sends only the window command;
// operation set cursor sends the six-byte window command, or nothing when
// line or column is out of range.
// rsp carries one byte per handshake with is_command and last, last marking
// the final byte of an item.
// an item is 0, 6 or 12 bytes, one byte per cycle through the single output
// register while rsp is not stalled; an item with no bytes ends at its handshake.
// a first byte passes the step register, then the output register; the font row is
// read from the table into a register at acceptance, used from the next cycle.
// the next item is taken in the cycle the last byte of the current one is
// loaded, so items follow with no gap.
// reset clears page and cursor to zero and empties the output register.
// a stalled rsp holds the shown byte and stops the sequencer; req is not
// taken until the current item's last byte has been loaded.
`timescale 1ns / 1ps

module text_glyph_column_writer
    import tgcw_pkg::*;
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    tgcw_stream_if.sink   req,
    tgcw_stream_if.source rsp
);

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int PAGE_W = $clog2(PAGES);

    logic [PAGE_W-1:0] page_reg, page_next;
    logic [COL_W-1:0]  cursor_reg, cursor_next;

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0] end_step_reg;
    logic [PAGE_W-1:0] win_page_reg;
    logic [COL_W-1:0]  win_col_reg;
    font_row_t         font_row_reg;

    logic              out_valid_reg, out_valid_next;
    tgcw_byte_t        out_data_reg, out_data_next;

    tgcw_cmd_t         cmd;
    logic              out_free;
    logic              seq_last;
    logic              accept;
    logic              is_set;
    logic              set_ok;
    logic              is_nl;
    logic              edge_hit;
    logic              wrap;
    logic              glyph;
    logic              win;
    logic              has_work;
    logic [COL_W:0]    cur_ext;
    logic [COL_W:0]    adv;
    logic [COL_W-1:0]  adv_base;
    logic [PAGE_W-1:0] page_inc;
    logic [PAGE_W-1:0] job_page;
    logic [COL_W-1:0]  job_col;
    logic [7:0]        glyph_sub;
    glyph_idx_t        glyph_idx;
    logic [7:0]        step_byte;
    logic              step_cmd;

    assign cmd      = req.data;
    assign out_free = !out_valid_reg || rsp.ready;
    assign seq_last = busy_reg && (step_reg == end_step_reg);
    assign req.ready = !busy_reg || (seq_last && out_free);
    assign accept   = req.valid && req.ready;

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // decode of the incoming item against current page and cursor
    always_comb
    begin
        is_set    = (cmd.operation == OP_SET_CURSOR);
        set_ok    = (cmd.line < 8'(PAGES)) && ({1'b0, cmd.column} < 9'(COLUMNS));
        is_nl     = (cmd.char_code == CH_NEWLINE);
        cur_ext   = {1'b0, cursor_reg} + (COL_W+1)'(GLYPH_WIDTH);
        edge_hit  = (cur_ext >= (COL_W+1)'(COLUMNS));
        wrap      = !is_set && (is_nl || edge_hit);
        glyph     = !is_set && !is_nl;
        win       = (is_set && set_ok) || wrap;
        has_work  = win || glyph;
        page_inc  = (page_reg == PAGE_W'(PAGES - 1)) ? '0 : page_reg + PAGE_W'(1);
        job_page  = is_set ? cmd.line[PAGE_W-1:0] : page_inc;
        job_col   = is_set ? cmd.column[COL_W-1:0] : '0;
        adv_base  = wrap ? '0 : cursor_reg;
        adv       = {1'b0, adv_base} + (COL_W+1)'(GLYPH_WIDTH + 1);
        glyph_sub = cmd.char_code - CH_FIRST;
        glyph_idx = ((cmd.char_code >= CH_FIRST) && (cmd.char_code <= CH_LAST))
                  ? glyph_sub[6:0] : '0;
    end

    // page and cursor update at acceptance
    always_comb
    begin
        page_next   = page_reg;
        cursor_next = cursor_reg;
        if (accept)
        begin
            if (win)
            begin
                page_next   = job_page;
                cursor_next = job_col;
            end
            if (glyph)
            begin
                cursor_next = (adv > (COL_W+1)'(COLUMNS - 1))
                            ? COL_W'(COLUMNS - 1) : adv[COL_W-1:0];
            end
        end
    end

    // byte sequencer
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        priority if (accept)
        begin
            busy_next = has_work;
            step_next = win ? STEP_COL_CMD : STEP_GLYPH0;
        end
        else if (busy_reg && out_free)
        begin
            busy_next = !seq_last;
            step_next = step_reg + STEP_W'(1);
        end
        else
        begin
            busy_next = busy_reg;
            step_next = step_reg;
        end
    end

    always_comb
    begin
        step_cmd = 1'b1;
        unique case (step_reg)
            STEP_COL_CMD:  step_byte = CMD_COL_ADDR;
            STEP_COL_LO:   step_byte = 8'(win_col_reg);
            STEP_COL_HI:   step_byte = 8'(COLUMNS - 1);
            STEP_PAGE_CMD: step_byte = CMD_PAGE_ADDR;
            STEP_PAGE_LO:  step_byte = 8'(win_page_reg);
            STEP_PAGE_HI:  step_byte = 8'(PAGES - 1);
            STEP_GLYPH0:
            begin
                step_byte = font_row_reg[39:32];
                step_cmd  = 1'b0;
            end
            STEP_GLYPH1:
            begin
                step_byte = font_row_reg[31:24];
                step_cmd  = 1'b0;
            end
            STEP_GLYPH2:
            begin
                step_byte = font_row_reg[23:16];
                step_cmd  = 1'b0;
            end
            STEP_GLYPH3:
            begin
                step_byte = font_row_reg[15:8];
                step_cmd  = 1'b0;
            end
            STEP_GLYPH4:
            begin
                step_byte = font_row_reg[7:0];
                step_cmd  = 1'b0;
            end
            default:
            begin
                step_byte = BLANK_COLUMN;
                step_cmd  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_free)
        begin
            out_valid_next           = busy_reg;
            out_data_next.out_byte   = step_byte;
            out_data_next.is_command = step_cmd;
            out_data_next.last       = seq_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg      <= '0;
            cursor_reg    <= '0;
            busy_reg      <= 1'b0;
            step_reg      <= STEP_COL_CMD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            page_reg      <= page_next;
            cursor_reg    <= cursor_next;
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output byte register, job payload and synchronous font read
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (accept)
        begin
            end_step_reg <= glyph ? STEP_BLANK : STEP_PAGE_HI;
            win_page_reg <= job_page;
            win_col_reg  <= job_col;
            font_row_reg <= FONT_ROM[glyph_idx];
        end
    end

endmodule

// ===== hw/rtl/tgcw_checker.sv =====
// port checker for the text glyph column writer, bound into text_glyph_column_writer
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tgcw_checker #(
    parameter int PAGES = 8
) (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] rsp_byte,
    input logic       rsp_is_command,
    input logic       rsp_last
);

    `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_byte) && $stable(rsp_is_command) && $stable(rsp_last), "stalled byte changed")
    `ASSERT_IMPL(a_data_ends_blank, rsp_valid && !rsp_is_command && rsp_last, rsp_byte == 8'h00, "character does not end on a blank column")
    `ASSERT_IMPL(a_cmd_ends_page_hi, rsp_valid && rsp_is_command && rsp_last, rsp_byte == 8'(PAGES - 1), "window command does not end on last page")
    `ASSERT_NEXT(a_burst_no_gap, rsp_valid && rsp_ready && !rsp_last, rsp_valid, "gap inside the bytes of one item")

endmodule

bind text_glyph_column_writer tgcw_checker #(
    .PAGES (PAGES)
) u_tgcw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_byte       (rsp.data.out_byte),
    .rsp_is_command (rsp.data.is_command),
    .rsp_last       (rsp.data.last)
);
